// ----- rtl/rcp_pkg.sv -----
package rcp_pkg;

	localparam int ANCHOR_DEPTH = 16;
	localparam int EVENT_DEPTH  = 32;
	localparam int EVENT_WIDTH  = 16;

	typedef enum logic [2:0] {
		OP_FRAME  = 3'd0,
		OP_EVENT  = 3'd1,
		OP_TRIM   = 3'd2,
		OP_REWIND = 3'd3,
		OP_BACK1  = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		K_ACK    = 3'd0,
		K_ANCHOR = 3'd1,
		K_HEADER = 3'd2,
		K_EVENT  = 3'd3,
		K_NOPLAN = 3'd4
	} kind_t;

	localparam logic CFG_INTERVAL = 1'b0;
	localparam logic CFG_WINDOW   = 1'b1;

endpackage

// ----- rtl/rcp_modunit.sv -----
// Restoring remainder of a 32-bit value by a 16-bit divisor, one bit a cycle.
module rcp_modunit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic        is_zero
);
	logic [31:0] num_q;
	logic [16:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] shl;
	logic [17:0] diff;

	assign shl  = {rem_q[15:0], num_q[31]};
	assign diff = {1'b0, shl} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				num_q  <= dividend;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[30:0], 1'b0};
				rem_q <= diff[17] ? shl : diff[16:0];
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign is_zero = (rem_q == '0);
endmodule

// ----- rtl/rewind_checkpoint_planner.sv -----
// channel | signals                                | accepted when
// in      | in_valid in_stall op frame event_data  | in_valid & !in_stall
// out     | out_valid out_stall kind ... last      | out_valid & !out_stall
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid & cfg_ready
// A frame begin waits on the bit-serial remainder in S_MOD, then goes through S_FRAME and S_OUT;
// event, clear, no-plan and other ops go straight to S_OUT with a single word.
// Trim walks one ring entry a cycle, anchors in S_TRIM_A and then events in S_TRIM_E.
// Rewind walks anchors (S_RW_A), counts events (S_RW_CNT), sends a header (S_RW_HDR),
// then replays each counted event word through S_RW_EV and S_OUT until the last is taken.
// arst_n empties both rings and restores register defaults; ring contents are undefined.
// A stalled output word holds; in_stall is high until the last word is taken, and also
// while cfg_valid is high so a config write goes ahead of the next input.
module rewind_checkpoint_planner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] frame,
	input  logic [15:0] event_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [3:0]  slot,
	output logic [31:0] base_frame,
	output logic [31:0] goal_frame,
	output logic [31:0] replay_len,
	output logic [31:0] event_offset,
	output logic [15:0] event_out,
	output logic        overflow,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int ANCHOR_DEPTH = rcp_pkg::ANCHOR_DEPTH;
	localparam int EVENT_DEPTH  = rcp_pkg::EVENT_DEPTH;
	localparam int EVENT_WIDTH  = rcp_pkg::EVENT_WIDTH;
	localparam int AW = (ANCHOR_DEPTH > 1) ? $clog2(ANCHOR_DEPTH) : 1;
	localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int PW = (EVENT_WIDTH < 16) ? EVENT_WIDTH : 16;

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_FRAME, S_TRIM_A, S_TRIM_E, S_RW_A, S_RW_CNT,
		S_RW_HDR, S_RW_EV, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] interval_q;
	logic [31:0] window_q;
	logic [31:0] anchor_mem [ANCHOR_DEPTH];
	logic [31:0] event_fmem [EVENT_DEPTH];
	logic [PW-1:0] event_pmem [EVENT_DEPTH];
	logic [AW-1:0] a_head_q;
	logic [AW:0]   a_count_q;
	logic [EW-1:0] e_head_q;
	logic [EW:0]   e_count_q;
	logic [31:0] frame_q, tf_q, af_q, oldest_q;
	logic [AW:0] idx_a_q;
	logic [EW:0] idx_e_q, n_q;
	logic [AW-1:0] chosen_q;
	logic        final_q;
	logic        in_acc;
	logic        mod_start, mod_done, mod_zero;
	logic [15:0] eff_int;
	logic [31:0] eff_win;
	logic [31:0] cutoff;
	logic [AW-1:0] a_rd, a_last;
	logic [EW-1:0] e_rd;
	logic [31:0] a_rd_frame, e_rd_frame;

	assign eff_int   = (interval_q == '0) ? 16'd1 : interval_q;
	assign eff_win   = (window_q < {16'd0, eff_int}) ? {16'd0, eff_int} : window_q;
	assign cutoff    = (frame_q > eff_win) ? frame_q - eff_win : '0;
	assign a_rd      = AW'((a_head_q + idx_a_q[AW-1:0]) % ANCHOR_DEPTH);
	assign a_last    = AW'((a_head_q + a_count_q - 1'b1) % ANCHOR_DEPTH);
	assign e_rd      = EW'((e_head_q + idx_e_q[EW-1:0]) % EVENT_DEPTH);
	assign a_rd_frame = anchor_mem[a_rd];
	assign e_rd_frame = event_fmem[e_rd];
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign mod_start = in_acc && (op == rcp_pkg::OP_FRAME);

	rcp_modunit u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(frame),
		.divisor(eff_int), .done(mod_done), .is_zero(mod_zero)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_FRAME && (a_count_q == '0 ||
				(mod_zero && anchor_mem[a_last] < frame_q)))
			anchor_mem[(a_count_q >= (AW+1)'(ANCHOR_DEPTH)) ? a_head_q :
				AW'((a_head_q + a_count_q) % ANCHOR_DEPTH)] <= frame_q;
		if (in_acc && op == rcp_pkg::OP_EVENT &&
				e_count_q < (EW+1)'(EVENT_DEPTH)) begin
			event_fmem[EW'((e_head_q + e_count_q) % EVENT_DEPTH)] <= frame;
			event_pmem[EW'((e_head_q + e_count_q) % EVENT_DEPTH)] <= event_data[PW-1:0];
		end
	end

	task automatic put(input rcp_pkg::kind_t k, input logic [3:0] s, input logic [31:0] af,
			input logic [31:0] tf, input logic [31:0] adv, input logic [31:0] off,
			input logic [15:0] ev, input logic ovf, input logic lst);
		kind <= k; slot <= s; base_frame <= af; goal_frame <= tf;
		replay_len <= adv; event_offset <= off; event_out <= ev;
		overflow <= ovf; last <= lst; out_valid <= 1'b1;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; interval_q <= 16'd60; window_q <= 32'd600;
			a_head_q <= '0; a_count_q <= '0; e_head_q <= '0; e_count_q <= '0;
			out_valid <= 1'b0; final_q <= 1'b0;
		end else begin
			unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					if (cfg_index == rcp_pkg::CFG_INTERVAL) interval_q <= cfg_data[15:0];
					else window_q <= cfg_data;
				end else if (in_valid) begin
					frame_q <= frame; idx_a_q <= '0; idx_e_q <= '0; n_q <= '0;
					final_q <= 1'b1;
					case (op)
					rcp_pkg::OP_FRAME: state_q <= S_MOD;
					rcp_pkg::OP_EVENT: begin
						put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0,
							e_count_q >= (EW+1)'(EVENT_DEPTH), 1'b1);
						if (e_count_q < (EW+1)'(EVENT_DEPTH)) e_count_q <= e_count_q + 1'b1;
						state_q <= S_OUT;
					end
					rcp_pkg::OP_TRIM: state_q <= S_TRIM_A;
					rcp_pkg::OP_REWIND: begin
						tf_q <= frame;
						if (a_count_q == '0) begin
							put(rcp_pkg::K_NOPLAN, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
							state_q <= S_OUT;
						end else state_q <= S_RW_A;
					end
					rcp_pkg::OP_BACK1: begin
						tf_q <= frame - 32'd1;
						if (a_count_q == '0 || frame == '0) begin
							put(rcp_pkg::K_NOPLAN, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
							state_q <= S_OUT;
						end else state_q <= S_RW_A;
					end
					rcp_pkg::OP_CLEAR: begin
						put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
						a_head_q <= '0; a_count_q <= '0; e_head_q <= '0; e_count_q <= '0;
						state_q <= S_OUT;
					end
					default: begin
						put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
						state_q <= S_OUT;
					end
					endcase
				end
			end
			S_MOD: if (mod_done) state_q <= S_FRAME;
			S_FRAME: begin
				if (a_count_q == '0 || (mod_zero && anchor_mem[a_last] < frame_q)) begin
					if (a_count_q >= (AW+1)'(ANCHOR_DEPTH)) begin
						// full ring: reuse the oldest slot
						put(rcp_pkg::K_ANCHOR, 4'(a_head_q), frame_q, '0, '0, '0, '0,
							1'b1, 1'b1);
						a_head_q <= AW'((a_head_q + 1'b1) % ANCHOR_DEPTH);
					end else begin
						put(rcp_pkg::K_ANCHOR, 4'((a_head_q + a_count_q) % ANCHOR_DEPTH),
							frame_q, '0, '0, '0, '0, 1'b0, 1'b1);
						a_count_q <= a_count_q + 1'b1;
					end
				end else begin
					put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
				end
				state_q <= S_OUT;
			end
			S_TRIM_A: begin
				// head anchor read directly at a_head_q
				if (a_count_q > 1 && anchor_mem[a_head_q] < cutoff) begin
					a_head_q <= AW'((a_head_q + 1'b1) % ANCHOR_DEPTH);
					a_count_q <= a_count_q - 1'b1;
				end else begin
					oldest_q <= anchor_mem[a_head_q];
					if (a_count_q == '0) begin
						put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
						state_q <= S_OUT;
					end else state_q <= S_TRIM_E;
				end
			end
			S_TRIM_E: begin
				if (e_count_q != '0 && event_fmem[e_head_q] < oldest_q) begin
					e_head_q <= EW'((e_head_q + 1'b1) % EVENT_DEPTH);
					e_count_q <= e_count_q - 1'b1;
				end else begin
					put(rcp_pkg::K_ACK, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
					state_q <= S_OUT;
				end
			end
			S_RW_A: begin
				if (idx_a_q == '0 || (idx_a_q < a_count_q && a_rd_frame <= tf_q)) begin
					if (idx_a_q == '0 || a_rd_frame <= tf_q) begin
						chosen_q <= a_rd;
						af_q <= a_rd_frame;
					end
					idx_a_q <= idx_a_q + 1'b1;
					if (idx_a_q + 1'b1 >= a_count_q) state_q <= S_RW_CNT;
				end else state_q <= S_RW_CNT;
			end
			S_RW_CNT: begin
				if (tf_q < af_q) tf_q <= af_q;
				if (idx_e_q < e_count_q && !(e_rd_frame >= af_q &&
						e_rd_frame >= ((tf_q < af_q) ? af_q : tf_q))) begin
					if (e_rd_frame >= af_q) n_q <= n_q + 1'b1;
					idx_e_q <= idx_e_q + 1'b1;
				end else begin
					idx_e_q <= '0;
					state_q <= S_RW_HDR;
				end
			end
			S_RW_HDR: begin
				put(rcp_pkg::K_HEADER, 4'(chosen_q), af_q, tf_q, tf_q - af_q, '0, '0,
					1'b0, n_q == '0);
				final_q <= (n_q == '0);
				state_q <= S_OUT;
			end
			S_RW_EV: begin
				if (e_rd_frame < af_q) idx_e_q <= idx_e_q + 1'b1;
				else begin
					put(rcp_pkg::K_EVENT, 4'(chosen_q), af_q, tf_q, tf_q - af_q,
						e_rd_frame - af_q, 16'(event_pmem[e_rd]), 1'b0, n_q == 1);
					final_q <= (n_q == 1);
					n_q <= n_q - 1'b1;
					idx_e_q <= idx_e_q + 1'b1;
					state_q <= S_OUT;
				end
			end
			S_OUT: begin
				if (out_valid && !out_stall) begin
					out_valid <= 1'b0;
					state_q <= final_q ? S_IDLE : S_RW_EV;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/rcp_checker.sv -----
module rcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] kind,
	input logic       last,
	input logic       cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind))
		else $error("stalled word changed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while word pending");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall) else $error("input open while busy");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == rcp_pkg::K_ACK || kind == rcp_pkg::K_ANCHOR ||
		kind == rcp_pkg::K_NOPLAN) |-> last) else $error("single word not last");
endmodule

bind rewind_checkpoint_planner rcp_checker u_rcp_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .last(last),
	.cfg_ready(cfg_ready)
);

// ----- tb/tb_rewind_checkpoint_planner.sv -----
module tb_rewind_checkpoint_planner;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] frame;
		logic [15:0] data;
	} cmd_t;

	typedef struct {
		rcp_pkg::kind_t kind;
		logic [3:0]  slot;
		logic [31:0] af;
		logic [31:0] tf;
		logic [31:0] fta;
		logic [31:0] off;
		logic [15:0] ev;
		logic        ovf;
		logic        last;
	} word_t;

	localparam int A_DEPTH = rcp_pkg::ANCHOR_DEPTH;
	localparam int E_DEPTH = rcp_pkg::EVENT_DEPTH;
	localparam int WDOG_LIMIT = 6000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = 3'd0;
	logic [31:0] frame = 32'd0;
	logic [15:0] event_data = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [3:0]  slot;
	logic [31:0] base_frame, goal_frame, replay_len, event_offset;
	logic [15:0] event_out;
	logic        overflow, last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = rcp_pkg::CFG_INTERVAL;
	logic [31:0] cfg_data = 32'd0;

	rewind_checkpoint_planner u_top (.*);

	// predictor state
	logic [15:0] p_interval;
	logic [31:0] p_window;
	logic [31:0] a_fr [A_DEPTH];
	int          a_head, a_cnt;
	logic [31:0] e_fr [E_DEPTH];
	logic [15:0] e_pl [E_DEPTH];
	int          e_head, e_cnt;

	cmd_t  cmd_q[$];
	word_t plan_q[$];
	cmd_t  cur;
	int    in_gap, out_gap, fails, idle_cycles;
	bit    no_idle;

	initial forever #5 clk = ~clk;

	function automatic void push_word(rcp_pkg::kind_t k, int s, logic [31:0] af,
			logic [31:0] tf, logic [31:0] off, logic [15:0] ev, logic ovf, logic lst);
		word_t w;
		w.kind = k; w.slot = s[3:0]; w.af = af; w.tf = tf;
		w.fta = (k == rcp_pkg::K_HEADER || k == rcp_pkg::K_EVENT) ? tf - af : 32'd0;
		w.off = off; w.ev = ev; w.ovf = ovf; w.last = lst;
		plan_q = {plan_q, w};
	endfunction

	function automatic void plan_rewind(logic [31:0] tgt);
		int chosen, s;
		logic [31:0] af, tf;
		int hits[$];
		if (a_cnt == 0) begin
			push_word(rcp_pkg::K_NOPLAN, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		chosen = 0;
		for (int i = 0; i < a_cnt; i++) begin
			if (a_fr[(a_head + i) % A_DEPTH] <= tgt) chosen = i;
			else break;
		end
		s = (a_head + chosen) % A_DEPTH;
		af = a_fr[s];
		tf = (tgt < af) ? af : tgt;
		// oldest first: skip early events, stop at first one at/after target
		for (int i = 0; i < e_cnt; i++) begin
			if (e_fr[(e_head + i) % E_DEPTH] < af) continue;
			if (e_fr[(e_head + i) % E_DEPTH] >= tf) break;
			hits = {hits, (e_head + i) % E_DEPTH};
		end
		push_word(rcp_pkg::K_HEADER, s, af, tf, 0, 0, 0, hits.size() == 0);
		foreach (hits[j])
			push_word(rcp_pkg::K_EVENT, s, af, tf, e_fr[hits[j]] - af, e_pl[hits[j]], 0,
				j == hits.size() - 1);
	endfunction

	function automatic void plan_step(cmd_t c);
		logic [31:0] ivl, win, cutoff;
		bit take, ovf;
		int s;
		ivl = (p_interval == 0) ? 32'd1 : {16'd0, p_interval};
		case (c.op)
			rcp_pkg::OP_FRAME: begin
				take = (a_cnt == 0);
				ovf = 0;
				if (!take && c.frame % ivl == 0 &&
						a_fr[(a_head + a_cnt - 1) % A_DEPTH] < c.frame)
					take = 1;
				if (!take) begin
					push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 0, 1);
				end else begin
					if (a_cnt >= A_DEPTH) begin
						a_head = (a_head + 1) % A_DEPTH;
						a_cnt--;
						ovf = 1;
					end
					s = (a_head + a_cnt) % A_DEPTH;
					a_fr[s] = c.frame;
					a_cnt++;
					push_word(rcp_pkg::K_ANCHOR, s, c.frame, 0, 0, 0, ovf, 1);
				end
			end
			rcp_pkg::OP_EVENT: begin
				if (e_cnt >= E_DEPTH) begin
					push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 1, 1);
				end else begin
					e_fr[(e_head + e_cnt) % E_DEPTH] = c.frame;
					e_pl[(e_head + e_cnt) % E_DEPTH] = c.data;
					e_cnt++;
					push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 0, 1);
				end
			end
			rcp_pkg::OP_TRIM: begin
				win = (p_window < ivl) ? ivl : p_window;
				cutoff = (c.frame > win) ? c.frame - win : 32'd0;
				while (a_cnt > 1 && a_fr[a_head] < cutoff) begin
					a_head = (a_head + 1) % A_DEPTH;
					a_cnt--;
				end
				if (a_cnt > 0)
					while (e_cnt > 0 && e_fr[e_head] < a_fr[a_head]) begin
						e_head = (e_head + 1) % E_DEPTH;
						e_cnt--;
					end
				push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 0, 1);
			end
			rcp_pkg::OP_REWIND: plan_rewind(c.frame);
			rcp_pkg::OP_BACK1: begin
				if (c.frame == 0) push_word(rcp_pkg::K_NOPLAN, 0, 0, 0, 0, 0, 0, 1);
				else plan_rewind(c.frame - 1);
			end
			rcp_pkg::OP_CLEAR: begin
				a_head = 0; a_cnt = 0; e_head = 0; e_cnt = 0;
				push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 0, 1);
			end
			default: push_word(rcp_pkg::K_ACK, 0, 0, 0, 0, 0, 0, 1);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				plan_step(cur);
				in_gap = pick_gap();
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					cur = cmd_q[0];
					cmd_q.delete(0);
					op <= cur.op;
					frame <= cur.frame;
					event_data <= cur.data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, got_v);
			fails++;
		end
	endfunction

	// output monitor
	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (plan_q.size() == 0) begin
					$display("%0t: unexpected word, kind %0d", $realtime, kind);
					fails++;
				end else begin
					w = plan_q[0];
					plan_q.delete(0);
					check_field("kind", w.kind, kind);
					check_field("slot", w.slot, slot);
					check_field("base_frame", w.af, base_frame);
					check_field("goal_frame", w.tf, goal_frame);
					check_field("replay_len", w.fta, replay_len);
					check_field("event_offset", w.off, event_offset);
					check_field("event_out", w.ev, event_out);
					check_field("overflow", w.ovf, overflow);
					check_field("last", w.last, last);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on accept activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("rewind_checkpoint_planner verification failed");
			$finish;
		end
	end

	task automatic add(logic [2:0] o, logic [31:0] f, logic [15:0] d = 16'd0);
		cmd_t c;
		c.op = o; c.frame = f; c.data = d;
		cmd_q = {cmd_q, c};
	endtask

	task automatic wait_idle();
		while (cmd_q.size() > 0 || in_valid || plan_q.size() > 0 || in_stall)
			@(negedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == rcp_pkg::CFG_INTERVAL) p_interval = val[15:0];
		else p_window = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// play session: ordered frames advance, events stamped near now, plus random-frame ops mixed in
	task automatic session(int n, logic [31:0] start);
		logic [31:0] now, ivl;
		int r;
		now = start;
		ivl = (p_interval == 0) ? 32'd1 : {16'd0, p_interval};
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				add(rcp_pkg::OP_FRAME, now);
				if ($urandom_range(0, 2) == 0) now += ivl - now % ivl;
				else now += $urandom_range(1, 3);
			end else if (r < 60)
				add(rcp_pkg::OP_EVENT, now - $urandom_range(0, 4), 16'($urandom));
			else if (r < 70) add(rcp_pkg::OP_TRIM, now);
			else if (r < 82) add(rcp_pkg::OP_REWIND, now - $urandom_range(0, 3 * ivl + 5));
			else if (r < 88) add(rcp_pkg::OP_BACK1, now);
			else if (r < 90) add(rcp_pkg::OP_CLEAR, $urandom);
			else if (r < 93) add(3'($urandom_range(6, 7)), $urandom, 16'($urandom));
			else add(3'($urandom_range(0, 7)), $urandom, 16'($urandom));
		end
	endtask

	initial begin
		p_interval = 16'd60;
		p_window = 32'd600;
		a_head = 0; a_cnt = 0; e_head = 0; e_cnt = 0;
		in_gap = 0; out_gap = 0; fails = 0; idle_cycles = 0; no_idle = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		add(rcp_pkg::OP_REWIND, 32'd100);
		add(rcp_pkg::OP_BACK1, 32'd0);
		add(rcp_pkg::OP_TRIM, 32'd5000);
		add(rcp_pkg::OP_FRAME, 32'd0);
		add(rcp_pkg::OP_EVENT, 32'd0, 16'hFFFF);
		add(rcp_pkg::OP_EVENT, 32'hFFFF_FFFF, 16'h0000);
		add(rcp_pkg::OP_FRAME, 32'd60);
		add(rcp_pkg::OP_FRAME, 32'd61);
		add(rcp_pkg::OP_FRAME, 32'd60);
		add(rcp_pkg::OP_EVENT, 32'd130, 16'h1234);
		add(rcp_pkg::OP_EVENT, 32'd125, 16'h5678);
		add(rcp_pkg::OP_EVENT, 32'd61, 16'hA5A5);
		add(rcp_pkg::OP_FRAME, 32'd120);
		add(rcp_pkg::OP_REWIND, 32'd100);
		add(rcp_pkg::OP_REWIND, 32'd200);
		add(rcp_pkg::OP_BACK1, 32'd131);
		add(rcp_pkg::OP_REWIND, 32'hFFFF_FFFF);
		add(rcp_pkg::OP_TRIM, 32'd1000);
		add(3'd6, 32'hFFFF_FFFF, 16'hFFFF);
		add(3'd7, 32'd0, 16'd0);
		add(rcp_pkg::OP_CLEAR, 32'd0);
		add(rcp_pkg::OP_FRAME, 32'd50);
		add(rcp_pkg::OP_REWIND, 32'd10);
		add(rcp_pkg::OP_BACK1, 32'd1);
		wait_idle();

		// interval 1: fill both rings past capacity
		write_reg(rcp_pkg::CFG_INTERVAL, 32'd1);
		write_reg(rcp_pkg::CFG_WINDOW, 32'd1);
		no_idle = 1;
		for (int i = 0; i < 18; i++) add(rcp_pkg::OP_FRAME, i);
		for (int i = 0; i < 34; i++)
			add(rcp_pkg::OP_EVENT, $urandom_range(0, 20), 16'($urandom));
		add(rcp_pkg::OP_REWIND, 32'd12);
		add(rcp_pkg::OP_TRIM, 32'd17);
		add(rcp_pkg::OP_REWIND, 32'd40);
		session(25, 32'd18);
		wait_idle();
		no_idle = 0;

		write_reg(rcp_pkg::CFG_INTERVAL, 32'd65535);
		write_reg(rcp_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
		session(20, 32'hFFFF_0000 - 3);
		wait_idle();

		write_reg(rcp_pkg::CFG_INTERVAL, 32'd4);
		write_reg(rcp_pkg::CFG_WINDOW, 32'd20);
		add(rcp_pkg::OP_CLEAR, 32'd0);
		session(30, 32'd0);
		wait_idle();

		write_reg(rcp_pkg::CFG_INTERVAL, $urandom_range(2, 8));
		write_reg(rcp_pkg::CFG_WINDOW, $urandom);
		session(25, $urandom);
		wait_idle();

		write_reg(rcp_pkg::CFG_INTERVAL, 32'd3);
		write_reg(rcp_pkg::CFG_WINDOW, $urandom_range(1, 12));
		add(rcp_pkg::OP_CLEAR, 32'd0);
		session(30, 32'd7);
		wait_idle();

		if (fails == 0 && plan_q.size() == 0)
			$display("rewind_checkpoint_planner verification clean");
		else
			$display("rewind_checkpoint_planner verification failed");
		$finish;
	end

endmodule
